FILE: sv/sdl_pkg.sv
// shared constants, types and state encodings for the stereo delay line
package sdl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int RING_BITS   = 12;
  localparam int DELAY_BITS  = 12;
  localparam int LEN_BITS    = 16;
  localparam int REQ_BITS    = 16;
  localparam int CMD_BITS    = 2;
  localparam int CFG_BITS    = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + REQ_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + DELAY_BITS + 7) / 8) * 8;
  localparam int FRAME_BITS    = 2 * SAMPLE_BITS;

  // blend unit widths
  localparam int OPND_BITS = SAMPLE_BITS + 1;
  localparam int DIFF_BITS = SAMPLE_BITS + 2;
  localparam int PROD_BITS = LEN_BITS + SAMPLE_BITS + 3;
  localparam int MAG_BITS  = LEN_BITS + SAMPLE_BITS;
  localparam int NUM_BITS  = MAG_BITS + 2;
  localparam int QUO_BITS  = SAMPLE_BITS;
  localparam int REM_BITS  = LEN_BITS + 2;
  localparam int DIV_BITS  = LEN_BITS + 1;
  localparam int CNT_BITS  = $clog2(QUO_BITS);

  localparam logic [CMD_BITS-1:0] CMD_SAMPLE    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_SET_DELAY = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED    = 2'd3;

  localparam logic [CFG_BITS-1:0] CFG_FADE_LENGTH = 2'd0;
  localparam logic [CFG_BITS-1:0] CFG_DELAY_LIMIT = 2'd1;

  localparam logic [LEN_BITS-1:0]   FADE_LENGTH_RESET = 16'd480;
  localparam logic [DELAY_BITS-1:0] DELAY_LIMIT_RESET = 12'd4095;

  typedef struct packed {
    logic signed [OPND_BITS-1:0] a;
    logic signed [OPND_BITS-1:0] b;
    logic [LEN_BITS-1:0]         pos;
    logic [LEN_BITS-1:0]         len;
  } blend_req_t;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_MUL,
    BL_LOAD,
    BL_DIV,
    BL_DONE
  } blend_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ_NEW,
    ST_READ_OLD,
    ST_CAPTURE,
    ST_LEFT_GO,
    ST_LEFT_WAIT,
    ST_RIGHT_GO,
    ST_RIGHT_WAIT,
    ST_SNAP_GO,
    ST_SNAP_WAIT,
    ST_FINISH
  } seq_state_t;

endpackage

FILE: sv/sdl_ram.sv
// frame ring memory: one write port, one registered read port
module sdl_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sdl_blend.sv
// shared blend unit: a + round(pos * (b - a) / len) by serial restoring division
module sdl_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  sdl_pkg::blend_req_t                   req,
  output logic                                  done,
  output logic signed [sdl_pkg::OPND_BITS-1:0]  result
);

  sdl_pkg::blend_state_t state, state_next;

  logic signed [sdl_pkg::OPND_BITS-1:0] a_q;
  logic signed [sdl_pkg::DIFF_BITS-1:0] diff;
  logic [sdl_pkg::LEN_BITS-1:0]         pos_q;
  logic [sdl_pkg::LEN_BITS-1:0]         len_q;
  logic signed [sdl_pkg::PROD_BITS-1:0] prod;
  logic                                 neg;
  logic [sdl_pkg::REM_BITS-1:0]         rem;
  logic [sdl_pkg::QUO_BITS-1:0]         num_lo;
  logic [sdl_pkg::QUO_BITS-1:0]         quo;
  logic [sdl_pkg::CNT_BITS-1:0]         cnt;
  logic                                 done_q;

  logic                                 take;
  logic                                 mul_en;
  logic                                 load_en;
  logic                                 div_en;
  logic                                 fin_en;

  logic [sdl_pkg::PROD_BITS-1:0]        prod_abs;
  logic [sdl_pkg::NUM_BITS-1:0]         num;
  logic [sdl_pkg::DIV_BITS-1:0]         divisor;
  logic [sdl_pkg::REM_BITS-1:0]         trial;
  logic                                 qbit;

  always_comb begin
    state_next = state;
    case (state)
      sdl_pkg::BL_IDLE: begin
        if (start) begin
          state_next = sdl_pkg::BL_MUL;
        end
      end
      sdl_pkg::BL_MUL:  state_next = sdl_pkg::BL_LOAD;
      sdl_pkg::BL_LOAD: state_next = sdl_pkg::BL_DIV;
      sdl_pkg::BL_DIV: begin
        if (cnt == sdl_pkg::CNT_BITS'(sdl_pkg::QUO_BITS - 1)) begin
          state_next = sdl_pkg::BL_DONE;
        end
      end
      sdl_pkg::BL_DONE: state_next = sdl_pkg::BL_IDLE;
      default:          state_next = sdl_pkg::BL_IDLE;
    endcase
  end

  always_comb begin
    take    = 1'b0;
    mul_en  = 1'b0;
    load_en = 1'b0;
    div_en  = 1'b0;
    fin_en  = 1'b0;
    case (state)
      sdl_pkg::BL_IDLE: take    = start;
      sdl_pkg::BL_MUL:  mul_en  = 1'b1;
      sdl_pkg::BL_LOAD: load_en = 1'b1;
      sdl_pkg::BL_DIV:  div_en  = 1'b1;
      sdl_pkg::BL_DONE: fin_en  = 1'b1;
      default:          take    = 1'b0;
    endcase
  end

  // numerator 2*|p| + len over divisor 2*len gives round half away from zero
  always_comb begin
    prod_abs = prod[sdl_pkg::PROD_BITS-1] ? (sdl_pkg::PROD_BITS'(0) - prod) : prod;
    num      = {1'b0, prod_abs[sdl_pkg::MAG_BITS-1:0], 1'b0}
             + {{(sdl_pkg::NUM_BITS - sdl_pkg::LEN_BITS){1'b0}}, len_q};
    divisor  = {len_q, 1'b0};
    trial    = {rem[sdl_pkg::REM_BITS-2:0], num_lo[sdl_pkg::QUO_BITS-1]};
    qbit     = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sdl_pkg::BL_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= fin_en;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_q   <= req.a;
      diff  <= sdl_pkg::DIFF_BITS'(req.b) - sdl_pkg::DIFF_BITS'(req.a);
      pos_q <= req.pos;
      len_q <= req.len;
    end
    if (mul_en) begin
      prod <= $signed({1'b0, pos_q}) * diff;
    end
    if (load_en) begin
      neg    <= prod[sdl_pkg::PROD_BITS-1];
      rem    <= num[sdl_pkg::NUM_BITS-1:sdl_pkg::QUO_BITS];
      num_lo <= num[sdl_pkg::QUO_BITS-1:0];
      quo    <= '0;
      cnt    <= '0;
    end
    if (div_en) begin
      rem    <= qbit ? (trial - {1'b0, divisor}) : trial;
      num_lo <= {num_lo[sdl_pkg::QUO_BITS-2:0], 1'b0};
      quo    <= {quo[sdl_pkg::QUO_BITS-2:0], qbit};
      cnt    <= cnt + 1'b1;
    end
    if (fin_en) begin
      result <= neg ? (a_q - $signed({1'b0, quo})) : (a_q + $signed({1'b0, quo}));
    end
  end

  assign done = done_q;

endmodule

FILE: sv/stereo_delay_line_crossfade_unit.sv
// stereo delay line over a frame ring with linear crossfade on delay changes
// one beat at a time; clear and set-delay beats go straight to the result, but an accepted delay
// change mid-fade first snaps the old delay in a blend pass (16 divider steps); a sample beat
// writes the ring, reads both taps and, mid-fade, blends left then right; s_tready returns with the result
// reset is synchronous; the ring needs no clearing pass: a wrap flag and the
// write pointer mark which entries were written since reset or the last clear
module stereo_delay_line_crossfade_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // left_in [15:0], right_in [31:16], requested_delay [47:32]
  input  logic [sdl_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // command [1:0]
  input  logic [sdl_pkg::CMD_BITS-1:0]       s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // left_out [15:0], right_out [31:16], delay_now [43:32], zero pad [47:44]
  output logic [sdl_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // accepted [0], fading [1]
  output logic [1:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sdl_pkg::CFG_BITS-1:0]       cfg_index,
  input  logic [sdl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB = sdl_pkg::SAMPLE_BITS;
  localparam int DB = sdl_pkg::DELAY_BITS;
  localparam int LB = sdl_pkg::LEN_BITS;
  localparam int RB = sdl_pkg::RING_BITS;

  sdl_pkg::seq_state_t state, state_next;

  // configuration and core state
  logic [LB-1:0] fade_length, fade_length_next;
  logic [DB-1:0] delay_limit, delay_limit_next;
  logic [RB-1:0] wp, wp_next;
  logic          wrapped, wrapped_next;
  logic [DB-1:0] old_delay, old_delay_next;
  logic [DB-1:0] new_delay, new_delay_next;
  logic [LB-1:0] fade_pos, fade_pos_next;

  // latched item
  logic [sdl_pkg::CMD_BITS-1:0] cmd_q;
  logic signed [SB-1:0]         left_q;
  logic signed [SB-1:0]         right_q;
  logic [sdl_pkg::REQ_BITS-1:0] req_q;

  // frames read from the ring and blend results
  logic signed [SB-1:0] new_l, new_r, old_l, old_r, blend_l;
  logic                 rvalid;

  // output register
  logic [sdl_pkg::OUT_DATA_BITS-1:0] out_data, out_data_next;
  logic [1:0]                        out_user, out_user_next;
  logic                              out_valid;

  // control
  logic                            accept_in;
  logic                            cfg_fire;
  logic                            finish;
  logic                            ram_we;
  logic [RB-1:0]                   raddr;
  logic [sdl_pkg::FRAME_BITS-1:0]  rdata;
  logic                            blend_start;
  sdl_pkg::blend_req_t             blend_req;
  logic                            blend_done;
  logic signed [sdl_pkg::OPND_BITS-1:0] blend_res;

  logic [LB-1:0] len_eff;
  logic          fading_now;
  logic          req_ok;
  logic          req_change;
  logic [RB-1:0] tap_new;
  logic [RB-1:0] tap_old;
  logic [LB-1:0] pos_inc;
  logic [sdl_pkg::REQ_BITS-1:0] in_req;
  logic          snap_go;

  assign len_eff    = (fade_length == '0) ? LB'(1) : fade_length;
  assign fading_now = (fade_pos < len_eff);
  assign req_ok     = (req_q <= {{(sdl_pkg::REQ_BITS - DB){1'b0}}, delay_limit});
  assign req_change = (req_q[DB-1:0] != new_delay);
  assign tap_new    = wp - RB'(new_delay);
  assign tap_old    = wp - RB'(old_delay);
  assign pos_inc    = fade_pos + 1'b1;
  assign in_req     = s_tdata[2*SB+sdl_pkg::REQ_BITS-1:2*SB];
  assign snap_go    = fading_now
                      && (in_req <= {{(sdl_pkg::REQ_BITS - DB){1'b0}}, delay_limit})
                      && (in_req[DB-1:0] != new_delay);

  sdl_ram #(
    .ADDR_BITS (RB),
    .DATA_BITS (sdl_pkg::FRAME_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata ({right_q, left_q}),
    .raddr (raddr),
    .rdata (rdata)
  );

  sdl_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .start  (blend_start),
    .req    (blend_req),
    .done   (blend_done),
    .result (blend_res)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      sdl_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            sdl_pkg::CMD_SAMPLE: state_next = sdl_pkg::ST_WRITE;
            // an accepted delay change mid-fade snaps the old delay through the blend unit first
            sdl_pkg::CMD_SET_DELAY: begin
              state_next = snap_go ? sdl_pkg::ST_SNAP_GO : sdl_pkg::ST_FINISH;
            end
            default:             state_next = sdl_pkg::ST_FINISH;
          endcase
        end
      end
      sdl_pkg::ST_WRITE:    state_next = sdl_pkg::ST_READ_NEW;
      sdl_pkg::ST_READ_NEW: state_next = sdl_pkg::ST_READ_OLD;
      sdl_pkg::ST_READ_OLD: state_next = sdl_pkg::ST_CAPTURE;
      sdl_pkg::ST_CAPTURE: begin
        state_next = fading_now ? sdl_pkg::ST_LEFT_GO : sdl_pkg::ST_FINISH;
      end
      sdl_pkg::ST_LEFT_GO:  state_next = sdl_pkg::ST_LEFT_WAIT;
      sdl_pkg::ST_LEFT_WAIT: begin
        if (blend_done) begin
          state_next = sdl_pkg::ST_RIGHT_GO;
        end
      end
      sdl_pkg::ST_RIGHT_GO: state_next = sdl_pkg::ST_RIGHT_WAIT;
      sdl_pkg::ST_RIGHT_WAIT: begin
        if (blend_done) begin
          state_next = sdl_pkg::ST_FINISH;
        end
      end
      sdl_pkg::ST_SNAP_GO: state_next = sdl_pkg::ST_SNAP_WAIT;
      sdl_pkg::ST_SNAP_WAIT: begin
        if (blend_done) begin
          state_next = sdl_pkg::ST_FINISH;
        end
      end
      sdl_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          state_next = sdl_pkg::ST_IDLE;
        end
      end
      default: state_next = sdl_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready    = 1'b0;
    cfg_ready   = 1'b0;
    ram_we      = 1'b0;
    raddr       = tap_new;
    blend_start = 1'b0;
    finish      = 1'b0;
    blend_req.a   = $signed({{(sdl_pkg::OPND_BITS - DB){1'b0}}, old_delay});
    blend_req.b   = $signed({{(sdl_pkg::OPND_BITS - DB){1'b0}}, new_delay});
    blend_req.pos = fade_pos;
    blend_req.len = len_eff;
    case (state)
      sdl_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cfg_ready = 1'b1;
      end
      sdl_pkg::ST_WRITE:    ram_we = 1'b1;
      sdl_pkg::ST_READ_NEW: raddr  = tap_new;
      sdl_pkg::ST_READ_OLD: raddr  = tap_old;
      sdl_pkg::ST_LEFT_GO: begin
        blend_start = 1'b1;
        blend_req.a = sdl_pkg::OPND_BITS'(old_l);
        blend_req.b = sdl_pkg::OPND_BITS'(new_l);
      end
      sdl_pkg::ST_RIGHT_GO: begin
        blend_start = 1'b1;
        blend_req.a = sdl_pkg::OPND_BITS'(old_r);
        blend_req.b = sdl_pkg::OPND_BITS'(new_r);
      end
      sdl_pkg::ST_SNAP_GO: blend_start = 1'b1;
      sdl_pkg::ST_FINISH:  finish      = !out_valid || m_tready;
      default:             s_tready    = 1'b0;
    endcase
  end

  assign accept_in = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // state updates at the end of an item, config writes while idle
  always_comb begin
    fade_length_next = fade_length;
    delay_limit_next = delay_limit;
    wp_next          = wp;
    wrapped_next     = wrapped;
    old_delay_next   = old_delay;
    new_delay_next   = new_delay;
    fade_pos_next    = fade_pos;
    out_data_next    = out_data;
    out_user_next    = out_user;

    if (cfg_fire) begin
      case (cfg_index)
        sdl_pkg::CFG_FADE_LENGTH: begin
          fade_length_next = cfg_data[LB-1:0];
          old_delay_next   = new_delay;
          fade_pos_next    = (cfg_data[LB-1:0] == '0) ? LB'(1) : cfg_data[LB-1:0];
        end
        sdl_pkg::CFG_DELAY_LIMIT: delay_limit_next = cfg_data[DB-1:0];
        default:                  delay_limit_next = delay_limit;
      endcase
    end

    if (finish) begin
      out_data_next = '0;
      out_user_next = '0;
      case (cmd_q)
        sdl_pkg::CMD_SAMPLE: begin
          out_user_next[0] = 1'b1;
          if (fading_now) begin
            out_data_next[SB-1:0]    = blend_l;
            out_data_next[2*SB-1:SB] = blend_res[SB-1:0];
            fade_pos_next            = pos_inc;
            if (pos_inc >= len_eff) begin
              old_delay_next = new_delay;
            end
          end else begin
            out_data_next[SB-1:0]    = new_l;
            out_data_next[2*SB-1:SB] = new_r;
          end
          wp_next      = wp + 1'b1;
          wrapped_next = wrapped || (wp == '1);
        end
        sdl_pkg::CMD_SET_DELAY: begin
          if (req_ok) begin
            out_user_next[0] = 1'b1;
            if (req_change) begin
              old_delay_next = fading_now ? blend_res[DB-1:0] : new_delay;
              new_delay_next = req_q[DB-1:0];
              fade_pos_next  = '0;
            end
          end
        end
        sdl_pkg::CMD_CLEAR: begin
          out_user_next[0] = 1'b1;
          wp_next          = '0;
          wrapped_next     = 1'b0;
          old_delay_next   = new_delay;
          fade_pos_next    = len_eff;
        end
        default: out_user_next[0] = 1'b0;
      endcase
      out_data_next[2*SB+DB-1:2*SB] = new_delay_next;
      out_user_next[1] = (cmd_q != sdl_pkg::CMD_UNUSED) && (fade_pos_next < len_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sdl_pkg::ST_IDLE;
      fade_length <= sdl_pkg::FADE_LENGTH_RESET;
      delay_limit <= sdl_pkg::DELAY_LIMIT_RESET;
      wp          <= '0;
      wrapped     <= 1'b0;
      old_delay   <= '0;
      new_delay   <= '0;
      fade_pos    <= sdl_pkg::FADE_LENGTH_RESET;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fade_length <= fade_length_next;
      delay_limit <= delay_limit_next;
      wp          <= wp_next;
      wrapped     <= wrapped_next;
      old_delay   <= old_delay_next;
      new_delay   <= new_delay_next;
      fade_pos    <= fade_pos_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd_q   <= s_tuser;
      left_q  <= s_tdata[SB-1:0];
      right_q <= s_tdata[2*SB-1:SB];
      req_q   <= in_req;
    end
    // entries not written since reset or clear read as zero
    rvalid <= wrapped || (raddr <= wp);
    if (state == sdl_pkg::ST_READ_OLD) begin
      new_l <= rvalid ? rdata[SB-1:0] : '0;
      new_r <= rvalid ? rdata[2*SB-1:SB] : '0;
    end
    if (state == sdl_pkg::ST_CAPTURE) begin
      old_l <= rvalid ? rdata[SB-1:0] : '0;
      old_r <= rvalid ? rdata[2*SB-1:SB] : '0;
    end
    if (state == sdl_pkg::ST_LEFT_WAIT && blend_done) begin
      blend_l <= blend_res[SB-1:0];
    end
    out_data <= out_data_next;
    out_user <= out_user_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

`ifndef NO_ASSERTIONS
  // a settled delay line has no pending crossfade source
  a_settled_delays: assert property (@(posedge clk) disable iff (rst)
    !(fade_pos < len_eff) |-> (old_delay == new_delay))
    else $error("old and new delay differ outside a crossfade");

  // the blend unit reports only while the sequencer waits on it
  a_blend_done_waited: assert property (@(posedge clk) disable iff (rst)
    blend_done |-> (state == sdl_pkg::ST_LEFT_WAIT || state == sdl_pkg::ST_RIGHT_WAIT
                    || state == sdl_pkg::ST_SNAP_WAIT))
    else $error("blend result arrived with no waiting step");

  // rejected beats carry no audio
  a_rejected_silent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[2*SB-1:0] == '0))
    else $error("rejected result carries sample data");
`endif

endmodule

FILE: bench/stereo_delay_line_crossfade_unit_tb.sv
`timescale 1ns / 1ps
// testbench for the stereo delay line: directed and random beats checked against a local predictor
module stereo_delay_line_crossfade_unit_tb;
  import sdl_pkg::*;

  localparam int RING_FRAMES = 1 << RING_BITS;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS = 160;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          accepted;
    logic [DELAY_BITS-1:0]         delay_now;
    logic                          fading;
  } frame_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [CMD_BITS-1:0]      s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [1:0]               m_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predicted state of the delay line
  logic signed [SAMPLE_BITS-1:0] ring_left [RING_FRAMES];
  logic signed [SAMPLE_BITS-1:0] ring_right [RING_FRAMES];
  logic [RING_BITS-1:0]          wr_ptr;
  logic [DELAY_BITS-1:0]         cur_delay;
  logic [DELAY_BITS-1:0]         tgt_delay;
  int                            fade_pos;
  int                            fade_len;
  int                            delay_max;

  frame_result_t pending_frames[$];
  int            errors = 0;
  bit            tx_gaps = 1'b0;
  bit            rx_stalls = 1'b0;
  int            hold_cycles = 0;
  int            burst_left = 0;

  stereo_delay_line_crossfade_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int fade_span();
    return (fade_len == 0) ? 1 : fade_len;
  endfunction

  // a + round(pos*(b-a)/len), ties away from zero
  function automatic longint crossfade(longint a, longint b, int pos, int len);
    longint p;
    longint mag;
    longint q;
    p = longint'(pos) * (b - a);
    mag = (p < 0) ? -p : p;
    q = (mag * 2 + len) / (2 * longint'(len));
    return (p < 0) ? a - q : a + q;
  endfunction

  function automatic void end_fade();
    cur_delay = tgt_delay;
    fade_pos = fade_span();
  endfunction

  function automatic void empty_ring();
    for (int i = 0; i < RING_FRAMES; i++) begin
      ring_left[i] = '0;
      ring_right[i] = '0;
    end
    wr_ptr = '0;
  endfunction

  function automatic void reset_delay_line();
    empty_ring();
    cur_delay = '0;
    tgt_delay = '0;
    fade_len = FADE_LENGTH_RESET;
    delay_max = DELAY_LIMIT_RESET;
    fade_pos = fade_len;
  endfunction

  function automatic void advance_delay_line(logic [CMD_BITS-1:0] cmd,
                                             logic signed [SAMPLE_BITS-1:0] l,
                                             logic signed [SAMPLE_BITS-1:0] r,
                                             logic [REQ_BITS-1:0] req);
    frame_result_t res;
    logic [RING_BITS-1:0] tgt_idx;
    logic [RING_BITS-1:0] cur_idx;
    int span;
    span = fade_span();
    res.left = '0;
    res.right = '0;
    res.accepted = 1'b1;
    case (cmd)
      CMD_SAMPLE: begin
        ring_left[wr_ptr] = l;
        ring_right[wr_ptr] = r;
        tgt_idx = wr_ptr - tgt_delay;
        if (fade_pos < span) begin
          cur_idx = wr_ptr - cur_delay;
          res.left = SAMPLE_BITS'(crossfade(ring_left[cur_idx], ring_left[tgt_idx],
                                            fade_pos, span));
          res.right = SAMPLE_BITS'(crossfade(ring_right[cur_idx], ring_right[tgt_idx],
                                             fade_pos, span));
          fade_pos++;
          if (fade_pos >= span) cur_delay = tgt_delay;
        end else begin
          res.left = ring_left[tgt_idx];
          res.right = ring_right[tgt_idx];
        end
        wr_ptr = wr_ptr + 1'b1;
      end
      CMD_SET_DELAY: begin
        if (req > delay_max) begin
          res.accepted = 1'b0;
        end else if (req != tgt_delay) begin
          // a change mid-fade restarts from the interpolated delay
          if (fade_pos < span)
            cur_delay = DELAY_BITS'(crossfade(cur_delay, tgt_delay, fade_pos, span));
          else
            cur_delay = tgt_delay;
          tgt_delay = req[DELAY_BITS-1:0];
          fade_pos = 0;
        end
      end
      CMD_CLEAR: begin
        empty_ring();
        end_fade();
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
    res.delay_now = tgt_delay;
    res.fading = (cmd != CMD_UNUSED) && (fade_pos < fade_span());
    pending_frames.push_back(res);
  endfunction

  function automatic void check_field(string name, logic [SAMPLE_BITS-1:0] want,
                                      logic [SAMPLE_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result side: compare each beat with the oldest prediction
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, got %h / %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("left_out", want.left, m_tdata[SAMPLE_BITS-1:0]);
        check_field("right_out", want.right, m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        check_field("delay_now", SAMPLE_BITS'(want.delay_now),
                    SAMPLE_BITS'(m_tdata[2*SAMPLE_BITS+DELAY_BITS-1:2*SAMPLE_BITS]));
        check_field("accepted", SAMPLE_BITS'(want.accepted), SAMPLE_BITS'(m_tuser[0]));
        check_field("fading", SAMPLE_BITS'(want.fading), SAMPLE_BITS'(m_tuser[1]));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (rx_stalls && stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
      end
    end
  end

  // called and returns at a falling edge; valid stays high into the next call
  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [SAMPLE_BITS-1:0] l,
                           input logic [SAMPLE_BITS-1:0] r, input logic [REQ_BITS-1:0] req);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {req, r, l};
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    advance_delay_line(cmd, l, r, req);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
    send_item(CMD_SAMPLE, l, r, REQ_BITS'($urandom));
  endtask

  task automatic send_delay(input logic [REQ_BITS-1:0] req);
    send_item(CMD_SET_DELAY, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), req);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FADE_LENGTH) begin
      fade_len = value;
      end_fade();
    end else if (idx == CFG_DELAY_LIMIT) begin
      delay_max = value[DELAY_BITS-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_values();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_delay(16'd4096);
    send_delay(16'hFFFF);
    send_delay(16'd0);
    send_delay(16'd2);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h1234, 16'hEDCB);
    send_sample(16'hFFFF, 16'h0001);
    // change again while the first fade is still running
    send_delay(16'd4095);
    send_sample(16'h4000, 16'hC000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0001, 16'hFFFE);
    send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h2222, 16'hDDDD);
    send_sample(16'h3333, 16'hCCCC);
  endtask

  task automatic test_fade_completion();
    drain();
    write_register(CFG_FADE_LENGTH, 16'd4);
    write_register(CFG_DELAY_LIMIT, 16'd64);
    send_delay(16'd3);
    for (int i = 0; i < 6; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    send_delay(16'd3);
    send_delay(16'd65);
    send_delay(16'd64);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_delay(16'd1);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    send_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
  endtask

  task automatic test_zero_fade_length();
    drain();
    write_register(CFG_FADE_LENGTH, 16'd0);
    write_register(CFG_DELAY_LIMIT, 16'd4095);
    send_sample(16'h0100, 16'hFF00);
    send_sample(16'h0200, 16'hFE00);
    send_delay(16'd5);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    send_delay(16'd0);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  task automatic test_fade_length_write();
    drain();
    write_register(CFG_FADE_LENGTH, 16'd200);
    send_delay(16'd7);
    for (int i = 0; i < 4; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    drain();
    // a new fade length cuts the running fade short
    write_register(CFG_FADE_LENGTH, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    send_delay(16'd2);
    for (int i = 0; i < 3; i++) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
  endtask

  task automatic test_input_stall();
    drain();
    write_register(CFG_FADE_LENGTH, 16'd6);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 30; i++) begin
      if (i % 8 == 3) send_delay(REQ_BITS'($urandom_range(0, 12)));
      else send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    end
  endtask

  task automatic test_random_phases();
    int fade_set[6] = '{1, 5, 65535, 16, 0, 9};
    int limit_set[6] = '{4095, 16'hF00C, 4095, 0, 0, 300};
    int pick;
    int top;
    logic [SAMPLE_BITS-1:0] l;
    logic [SAMPLE_BITS-1:0] r;
    logic [REQ_BITS-1:0] req;
    fade_set[4] = $urandom_range(2, 40);
    limit_set[4] = $urandom_range(1, 4095);
    for (int p = 0; p < 6; p++) begin
      drain();
      write_register(CFG_FADE_LENGTH, CFG_DATA_BITS'(fade_set[p]));
      write_register(CFG_DELAY_LIMIT, CFG_DATA_BITS'(limit_set[p]));
      tx_gaps = (p % 2 == 1);
      rx_stalls = (p != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        l = SAMPLE_BITS'($urandom);
        r = SAMPLE_BITS'($urandom);
        req = REQ_BITS'($urandom);
        top = (delay_max < 24) ? delay_max : 24;
        if (pick < 72)
          send_item(CMD_SAMPLE, l, r, req);
        else if (pick < 82)
          send_item(CMD_SET_DELAY, l, r, REQ_BITS'($urandom_range(0, top)));
        else if (pick < 88)
          send_item(CMD_SET_DELAY, l, r, REQ_BITS'($urandom_range(0, delay_max)));
        else if (pick < 91)
          send_item(CMD_CLEAR, l, r, req);
        else if (pick < 94)
          send_item(CMD_UNUSED, l, r, req);
        else if (pick < 97)
          send_item(CMD_SET_DELAY, l, r, REQ_BITS'(delay_max + 1));
        else
          send_item(CMD_SET_DELAY, l, r, req);
      end
    end
  endtask

  initial begin
    reset_delay_line();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_fade_completion();
    test_zero_fade_length();
    test_fade_length_write();
    test_input_stall();
    test_random_phases();
    drain();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
sv/sdl_pkg.sv
sv/sdl_ram.sv
sv/sdl_blend.sv
sv/stereo_delay_line_crossfade_unit.sv
bench/stereo_delay_line_crossfade_unit_tb.sv
